// ===== hw/rtl/same_line_word_token_scanner_top_assert.svh =====
// Assertion macros for the same-line word token scanner checker.
`ifndef SAME_LINE_WORD_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SAME_LINE_WORD_TOKEN_SCANNER_TOP_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define SLWTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled in reset.
`define SLWTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/slwts_pkg.sv =====
// Shared types, codes and character constants of the word token scanner.
package slwts_pkg;

	// result status codes
	localparam logic [2:0] ST_ACCEPT    = 3'd0;
	localparam logic [2:0] ST_NONE_OK   = 3'd1;
	localparam logic [2:0] ST_LINE_END  = 3'd2;
	localparam logic [2:0] ST_NOT_IDENT = 3'd3;
	localparam logic [2:0] ST_KEYWORD   = 3'd4;

	// token kinds
	localparam logic KIND_CONT = 1'b0;
	localparam logic KIND_TYPE = 1'b1;

	// characters
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;

	// reserved words
	localparam int         NUM_KW     = 3;
	localparam logic [1:0] KW_RECORD  = 2'd0;
	localparam logic [1:0] KW_LIST_OF = 2'd1;
	localparam logic [1:0] KW_NOTE    = 2'd2;

	// output widths
	localparam int OUT_BITS     = 16;
	localparam int M_TDATA_BITS = 40;

	// work queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	// classified input transaction
	typedef struct packed {
		logic       start;
		logic       allow_cont;
		logic       allow_type;
		logic       at_end;
		logic [7:0] ch;
		logic       is_brk;
		logic       is_ws;
		logic       is_start;
		logic       is_word;
		logic       is_hyph;
		logic       is_lpar;
		logic       is_rpar;
	} item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                token_kind;
		logic [OUT_BITS-1:0] skipped;
		logic [OUT_BITS-1:0] token_length;
		logic                overflow;
	} res_t;

	function automatic logic [3:0] kw_len(input logic [1:0] k);
		logic [3:0] len;
		case (k)
			KW_RECORD:  len = 4'd6;
			KW_LIST_OF: len = 4'd7;
			KW_NOTE:    len = 4'd4;
			default:    len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] idx);
		logic [63:0] txt;
		case (k)
			KW_RECORD:  txt = {"record", 16'h0};
			KW_LIST_OF: txt = {"list_of", 8'h0};
			KW_NOTE:    txt = {"note", 32'h0};
			default:    txt = 64'h0;
		endcase
		return idx[3] ? 8'h00 : txt[8*(7-idx[2:0]) +: 8];
	endfunction

endpackage

// ===== hw/rtl/same_line_word_token_scanner_top.sv =====
// Top level of the same-line word token scanner: front, queue and scan back end.
// Throughput: one character transaction per cycle while results are taken and the queue has room,
//   limited by the per-character update of the scan state register in the back end.
// Path: a character is classified and written into the queue; the back end then takes it,
//   after any queued characters ahead of it, and registers the result on m_tdata/m_tuser.
// Reset: arst_n clears the scan state, queue pointers and the output valid at once.
module same_line_word_token_scanner_top #(
	parameter int COMPARE_CAP = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// character input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [3:0]  s_tuser,   // [0] start_req, [1] allow_continuation,
	                               // [2] allow_type, [3] at_end
	// scan results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] skipped, [31:16] token_length,
	                               // [32] overflow, [39:33] zero
	output logic [3:0]  m_tuser    // [2:0] status, [3] token_kind
);
	import slwts_pkg::*;

	// front to queue
	logic  push_valid;
	logic  push_ready;
	item_t push_item;

	// queue to back end
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	res_t  res;

	// Front: classify the character in the same cycle it is accepted.
	slwts_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue decouples input acceptance from output backpressure.
	slwts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Back end: scan state machine, one character per cycle unless the result stalls, registered result.
	slwts_back #(
		.COMPARE_CAP (COMPARE_CAP),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_item    (pop_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack result transaction
	assign m_tdata = {(M_TDATA_BITS - 2*OUT_BITS - 1)'(0), res.overflow, res.token_length,
		res.skipped};
	assign m_tuser = {res.token_kind, res.status};

endmodule

// ===== hw/rtl/slwts_front.sv =====
// Input side: takes character transactions and classifies each character.
module slwts_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic [3:0]           s_tuser,
	output logic                 push_valid,
	input  logic                 push_ready,
	output slwts_pkg::item_t     push_item
);
	import slwts_pkg::*;

	logic [7:0] ch;
	logic       is_alpha;
	logic       is_digit;

	assign ch       = s_tdata;
	assign is_alpha = (ch >= CH_LC_A && ch <= CH_LC_Z) || (ch >= CH_UC_A && ch <= CH_UC_Z)
		|| ch == CH_UNDER;
	assign is_digit = ch >= CH_DIG_0 && ch <= CH_DIG_9;

	always_comb begin
		push_item.start      = s_tuser[0];
		push_item.allow_cont = s_tuser[1];
		push_item.allow_type = s_tuser[2];
		push_item.at_end     = s_tuser[3];
		push_item.ch         = ch;
		push_item.is_brk     = ch == CH_LF || ch == CH_CR;
		push_item.is_ws      = ch == CH_SPACE || ch == CH_TAB || ch == CH_FF;
		push_item.is_start   = is_alpha;
		push_item.is_word    = is_alpha || is_digit;
		push_item.is_hyph    = ch == CH_HYPHEN;
		push_item.is_lpar    = ch == CH_LPAREN;
		push_item.is_rpar    = ch == CH_RPAREN;
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule

// ===== hw/rtl/slwts_queue.sv =====
// Short FIFO of classified characters between front and back.
module slwts_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  slwts_pkg::item_t     push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output slwts_pkg::item_t     pop_item
);
	import slwts_pkg::*;

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = count_q != (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== hw/rtl/slwts_back.sv =====
// Scan state machine: consumes classified characters and registers the result.
module slwts_back #(
	parameter int COMPARE_CAP = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  slwts_pkg::item_t     q_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output slwts_pkg::res_t      res
);
	import slwts_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SKIP  = 3'd1;
	localparam logic [2:0] PH_WORD  = 3'd2;
	localparam logic [2:0] PH_HYPH  = 3'd3;
	localparam logic [2:0] PH_PAREN = 3'd4;

	localparam int              EXT_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
	localparam logic [31:0]     KW_LIMIT = 32'(COMPARE_CAP - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [2:0]            phase_q;
	logic                  cont_q;
	logic [COUNT_BITS-1:0] skip_q;
	logic [COUNT_BITS-1:0] comm_q;
	logic [COUNT_BITS-1:0] pend_q;
	logic [3:0]            wlen_q;
	logic                  hyph_q;
	logic [2:0]            alive_q;
	logic                  ovf_q;

	logic                  res_valid_q;
	res_t                  res_q;

	// effective state after a possible restart
	logic [2:0]            e_phase;
	logic                  e_cont;
	logic [COUNT_BITS-1:0] e_skip, e_comm, e_pend;
	logic [3:0]            e_wlen;
	logic                  e_hyph;
	logic [2:0]            e_alive;
	logic                  e_ovf;
	logic                  none_ok;

	// next state
	logic [2:0]            n_phase;
	logic [COUNT_BITS-1:0] n_skip, n_comm, n_pend;
	logic [3:0]            n_wlen;
	logic                  n_hyph;
	logic [2:0]            n_alive;
	logic                  n_ovf;

	logic [COUNT_BITS-1:0] pend_inc, skip_inc;
	logic                  pend_sat, skip_sat;
	logic [2:0]            keep_vec, len_eq;
	logic                  is_kw;

	logic                  emit;
	logic [2:0]            st;
	logic                  kind;
	logic [COUNT_BITS-1:0] emit_len;
	logic [EXT_BITS-1:0]   skip_ext, len_ext;
	logic                  skip_clip, len_clip;
	logic                  fire;

	assign fire    = q_valid && (!res_valid_q || res_ready);
	assign q_ready = fire;

	always_comb begin
		if (q_item.start) begin
			e_cont  = q_item.allow_cont;
			e_skip  = '0;
			e_comm  = '0;
			e_pend  = '0;
			e_wlen  = '0;
			e_hyph  = 1'b0;
			e_alive = '1;
			e_ovf   = 1'b0;
			none_ok = !(q_item.allow_cont || q_item.allow_type);
			e_phase = none_ok ? PH_IDLE : PH_SKIP;
		end else begin
			e_cont  = cont_q;
			e_skip  = skip_q;
			e_comm  = comm_q;
			e_pend  = pend_q;
			e_wlen  = wlen_q;
			e_hyph  = hyph_q;
			e_alive = alive_q;
			e_ovf   = ovf_q;
			none_ok = 1'b0;
			e_phase = phase_q;
		end
	end

	// saturating increments and keyword tracking
	always_comb begin
		pend_sat = e_pend == CNT_MAX;
		skip_sat = e_skip == CNT_MAX;
		pend_inc = pend_sat ? e_pend : e_pend + COUNT_BITS'(1);
		skip_inc = skip_sat ? e_skip : e_skip + COUNT_BITS'(1);
		for (int k = 0; k < NUM_KW; k++) begin
			keep_vec[k] = (e_wlen < kw_len(2'(k))) && (q_item.ch == kw_char(2'(k), e_wlen));
			len_eq[k]   = e_wlen == kw_len(2'(k));
		end
		is_kw = !e_hyph && (32'(e_pend) < KW_LIMIT) && |(e_alive & len_eq);
	end

	always_comb begin
		n_phase  = e_phase;
		n_skip   = e_skip;
		n_comm   = e_comm;
		n_pend   = e_pend;
		n_wlen   = e_wlen;
		n_hyph   = e_hyph;
		n_alive  = e_alive;
		n_ovf    = e_ovf;
		emit     = 1'b0;
		st       = ST_ACCEPT;
		kind     = KIND_CONT;
		emit_len = '0;
		if (none_ok) begin
			emit = 1'b1;
			st   = ST_NONE_OK;
		end else begin
			case (e_phase)
				PH_SKIP: begin
					if (q_item.at_end || q_item.is_brk) begin
						emit = 1'b1;
						st   = ST_LINE_END;
					end else if (q_item.is_ws) begin
						n_skip = skip_inc;
						n_ovf  = e_ovf | skip_sat;
					end else if (!q_item.is_start) begin
						emit = 1'b1;
						st   = ST_NOT_IDENT;
					end else begin
						n_alive = e_alive & keep_vec;
						n_wlen  = (e_wlen < 4'd15) ? e_wlen + 4'd1 : e_wlen;
						n_pend  = pend_inc;
						n_comm  = pend_inc;
						n_ovf   = e_ovf | pend_sat;
						n_phase = PH_WORD;
					end
				end
				PH_WORD, PH_HYPH: begin
					if (!q_item.at_end && q_item.is_word) begin
						n_alive = e_alive & keep_vec;
						n_wlen  = (e_wlen < 4'd15) ? e_wlen + 4'd1 : e_wlen;
						n_pend  = pend_inc;
						n_comm  = pend_inc;
						n_ovf   = e_ovf | pend_sat;
						n_phase = PH_WORD;
					end else if (!q_item.at_end && q_item.is_hyph) begin
						// hyphens are held back until a word character follows
						n_pend  = pend_inc;
						n_ovf   = e_ovf | pend_sat;
						n_hyph  = 1'b1;
						n_phase = PH_HYPH;
					end else if (e_cont) begin
						emit     = 1'b1;
						kind     = KIND_CONT;
						emit_len = e_comm;
					end else if (is_kw) begin
						emit = 1'b1;
						st   = ST_KEYWORD;
					end else if (!q_item.at_end && q_item.is_lpar) begin
						n_pend  = pend_inc;
						n_ovf   = e_ovf | pend_sat;
						n_phase = PH_PAREN;
					end else begin
						emit     = 1'b1;
						kind     = KIND_TYPE;
						emit_len = e_comm;
					end
				end
				PH_PAREN: begin
					if (q_item.at_end) begin
						emit     = 1'b1;
						kind     = KIND_TYPE;
						emit_len = e_comm;
					end else begin
						n_pend = pend_inc;
						n_ovf  = e_ovf | pend_sat;
						if (q_item.is_rpar) begin
							n_comm   = pend_inc;
							emit     = 1'b1;
							kind     = KIND_TYPE;
							emit_len = pend_inc;
						end
					end
				end
				default: begin
					// idle without a start: character dropped
				end
			endcase
		end
		if (emit) n_phase = PH_IDLE;
	end

	// clamp counts to the output width
	always_comb begin
		skip_ext  = EXT_BITS'(n_skip);
		len_ext   = EXT_BITS'(emit_len);
		skip_clip = skip_ext > EXT_BITS'({OUT_BITS{1'b1}});
		len_clip  = len_ext > EXT_BITS'({OUT_BITS{1'b1}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cont_q      <= 1'b0;
			skip_q      <= '0;
			comm_q      <= '0;
			pend_q      <= '0;
			wlen_q      <= '0;
			hyph_q      <= 1'b0;
			alive_q     <= '1;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= n_phase;
				cont_q      <= e_cont;
				skip_q      <= n_skip;
				comm_q      <= n_comm;
				pend_q      <= n_pend;
				wlen_q      <= n_wlen;
				hyph_q      <= n_hyph;
				alive_q     <= n_alive;
				ovf_q       <= n_ovf;
				res_valid_q <= emit;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q.status       <= st;
			res_q.token_kind   <= kind;
			res_q.skipped      <= skip_clip ? '1 : skip_ext[OUT_BITS-1:0];
			res_q.token_length <= len_clip ? '1 : len_ext[OUT_BITS-1:0];
			res_q.overflow     <= n_ovf | skip_clip | len_clip;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/slwts_checker.sv =====
// Port-level checker for the word token scanner, bound to the top level.
`include "same_line_word_token_scanner_top_assert.svh"

module slwts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [3:0]  m_tuser
);
	import slwts_pkg::*;

	// stalled result holds
	`SLWTS_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	// only defined status codes
	`SLWTS_ASSERT_IMP(a_status_range, clk, arst_n, m_tvalid, m_tuser[2:0] <= ST_KEYWORD, "status code out of range")
	// kind and length are only given on accepted tokens
	`SLWTS_ASSERT_IMP(a_reject_clean, clk, arst_n, m_tvalid && m_tuser[2:0] != ST_ACCEPT, m_tuser[3] == KIND_CONT && m_tdata[31:16] == '0, "rejected scan carries kind or length")
	// nothing allowed: decided at the start, nothing skipped or counted
	`SLWTS_ASSERT_IMP(a_none_ok_empty, clk, arst_n, m_tvalid && m_tuser[2:0] == ST_NONE_OK, m_tdata[15:0] == '0 && m_tdata[32] == 1'b0, "no-token result has counts")

endmodule

bind same_line_word_token_scanner_top slwts_checker u_slwts_checker (.*);

// ===== verif/same_line_word_token_scanner_top_tb.sv =====
// Self-checking testbench of the same-line word token scanner top level.
module same_line_word_token_scanner_top_tb;
	import slwts_pkg::*;

	localparam int SCAN_CMP_CAP  = 16;
	localparam int SCAN_CNT_BITS = 16;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int PRINT_CAP     = 100;

	typedef enum logic [2:0] {SC_IDLE, SC_SKIP, SC_WORD, SC_HYPH, SC_PAREN} scan_phase_e;

	// one character transaction as offered to the block
	typedef struct {
		bit         st;
		bit         ac;
		bit         at;
		bit         en;
		logic [7:0] ch;
		bit         hold;   // wait for all outstanding results before sending
	} char_xact_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [3:0]  s_tuser = 4'h0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;

	same_line_word_token_scanner_top #(
		.COMPARE_CAP(SCAN_CMP_CAP),
		.COUNT_BITS (SCAN_CNT_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	char_xact_t chars_to_send[$];
	res_t       scan_results_due[$];
	int         chars_accepted = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	int         cycles = 0;
	int         total_chars = 0;

	string kw_text [NUM_KW] = '{"record", "list_of", "note"};

	// scan state of the predictor
	scan_phase_e p_phase = SC_IDLE;
	bit          p_cont = 1'b0;
	bit [15:0]   p_skip = '0;
	bit [15:0]   p_committed = '0;
	bit [15:0]   p_pending = '0;
	bit [3:0]    p_wlen = '0;
	bit          p_hyph = 1'b0;
	bit [2:0]    p_alive = 3'b111;
	bit          p_ovf = 1'b0;

	function automatic bit is_start_ch(logic [7:0] c);
		return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) || c == CH_UNDER;
	endfunction

	function automatic bit is_word_ch(logic [7:0] c);
		return is_start_ch(c) || (c >= CH_DIG_0 && c <= CH_DIG_9);
	endfunction

	function automatic bit is_hspace(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF;
	endfunction

	// saturating count step, flags overflow
	function automatic bit [15:0] sat_inc(bit [15:0] v);
		if (v == 16'hFFFF) begin
			p_ovf = 1'b1;
			return v;
		end
		return v + 16'd1;
	endfunction

	function automatic res_t close_scan(logic [2:0] st, logic kind, bit [15:0] len);
		res_t r;
		r.status       = st;
		r.token_kind   = kind;
		r.skipped      = p_skip;
		r.token_length = len;
		r.overflow     = p_ovf;
		p_phase = SC_IDLE;
		return r;
	endfunction

	function automatic void take_word_char(logic [7:0] c);
		for (int k = 0; k < NUM_KW; k++)
			if (p_wlen >= kw_text[k].len() || c != kw_text[k][p_wlen])
				p_alive[k] = 1'b0;
		if (p_wlen != 4'd15)
			p_wlen++;
		p_pending   = sat_inc(p_pending);
		p_committed = p_pending;
	endfunction

	function automatic bit is_keyword();
		if (p_hyph || p_pending >= 16'(SCAN_CMP_CAP - 1))
			return 1'b0;
		for (int k = 0; k < NUM_KW; k++)
			if (p_alive[k] && p_wlen == kw_text[k].len())
				return 1'b1;
		return 1'b0;
	endfunction

	// word ended; c is the lookahead right after it
	function automatic bit finish_word(bit at_eoi, logic [7:0] c, output res_t r);
		r = '0;
		if (p_cont) begin
			r = close_scan(ST_ACCEPT, KIND_CONT, p_committed);
			return 1'b1;
		end
		if (is_keyword()) begin
			r = close_scan(ST_KEYWORD, KIND_CONT, 16'd0);
			return 1'b1;
		end
		if (!at_eoi && c == CH_LPAREN) begin
			p_pending = sat_inc(p_pending);
			p_phase   = SC_PAREN;
			return 1'b0;
		end
		r = close_scan(ST_ACCEPT, KIND_TYPE, p_committed);
		return 1'b1;
	endfunction

	// advance the predicted scan by one character; returns 1 when a result falls due
	function automatic bit scan_step(char_xact_t x, output res_t r);
		r = '0;
		if (x.st) begin
			p_phase     = SC_IDLE;
			p_skip      = '0;
			p_committed = '0;
			p_pending   = '0;
			p_wlen      = '0;
			p_hyph      = 1'b0;
			p_alive     = 3'b111;
			p_ovf       = 1'b0;
			p_cont      = x.ac;
			if (!x.ac && !x.at) begin
				r = close_scan(ST_NONE_OK, KIND_CONT, 16'd0);
				return 1'b1;
			end
			p_phase = SC_SKIP;
		end
		case (p_phase)
			SC_SKIP: begin
				if (x.en || x.ch == CH_LF || x.ch == CH_CR) begin
					r = close_scan(ST_LINE_END, KIND_CONT, 16'd0);
					return 1'b1;
				end
				if (is_hspace(x.ch)) begin
					p_skip = sat_inc(p_skip);
					return 1'b0;
				end
				if (!is_start_ch(x.ch)) begin
					r = close_scan(ST_NOT_IDENT, KIND_CONT, 16'd0);
					return 1'b1;
				end
				take_word_char(x.ch);
				p_phase = SC_WORD;
				return 1'b0;
			end
			SC_WORD, SC_HYPH: begin
				if (x.en)
					return finish_word(1'b1, x.ch, r);
				if (is_word_ch(x.ch)) begin
					take_word_char(x.ch);
					p_phase = SC_WORD;
					return 1'b0;
				end
				if (x.ch == CH_HYPHEN) begin
					p_pending = sat_inc(p_pending);
					p_hyph    = 1'b1;
					p_phase   = SC_HYPH;
					return 1'b0;
				end
				return finish_word(1'b0, x.ch, r);
			end
			SC_PAREN: begin
				if (x.en) begin
					r = close_scan(ST_ACCEPT, KIND_TYPE, p_committed);
					return 1'b1;
				end
				p_pending = sat_inc(p_pending);
				if (x.ch == CH_RPAREN) begin
					p_committed = p_pending;
					r = close_scan(ST_ACCEPT, KIND_TYPE, p_committed);
					return 1'b1;
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic flag_mismatch(string what, longint want, longint got);
		if (mismatches < PRINT_CAP)
			$display("%0d: result %0d %s: want %0h got %0h", cycles, results_seen, what, want, got);
		mismatches++;
	endtask

	// ---------------- stimulus building ----------------

	task automatic add_item(bit st, bit ac, bit at, bit en, logic [7:0] c, bit hold = 1'b0);
		char_xact_t x;
		x.st   = st;
		x.ac   = ac;
		x.at   = at;
		x.en   = en;
		x.ch   = c;
		x.hold = hold;
		chars_to_send.push_back(x);
	endtask

	// mid-scan character; the allow flags are don't-care here and toggle freely
	task automatic add_char(logic [7:0] c);
		add_item(1'b0, $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, c);
	endtask

	task automatic add_eoi();
		add_item(1'b0, $urandom_range(0, 1), $urandom_range(0, 1), 1'b1, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] rand_ws();
		case ($urandom_range(0, 2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] rand_start_ch();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return CH_LC_A + 8'(r);
		if (r < 52)
			return CH_UC_A + 8'(r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_word_ch();
		if ($urandom_range(0, 4) == 0)
			return CH_DIG_0 + 8'($urandom_range(0, 9));
		return rand_start_ch();
	endfunction

	// a byte that cannot open a word and is neither blank nor a line end
	function automatic logic [7:0] rand_bad_start();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_start_ch(c) || is_hspace(c) || c == CH_LF || c == CH_CR);
		return c;
	endfunction

	// one well-formed scan with random content; bit 8 of a seq entry marks end of input
	task automatic gen_scan(bit hold);
		logic [8:0] seq[$];
		string      kw;
		int         n;
		int         r;
		bit         ac;
		bit         at;
		ac = $urandom_range(0, 1);
		at = ac ? bit'($urandom_range(0, 1)) : 1'b1;
		if ($urandom_range(0, 9) == 0) begin
			ac = 1'b0;
			at = 1'b0;
		end
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
		repeat (n) seq.push_back({1'b0, rand_ws()});
		r = $urandom_range(0, 11);
		if (r == 0) begin
			seq.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR});
		end else if (r == 1) begin
			seq.push_back({1'b1, 8'($urandom_range(0, 255))});
		end else if (r == 2) begin
			seq.push_back({1'b0, rand_bad_start()});
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				kw = kw_text[$urandom_range(0, NUM_KW - 1)];
				for (int i = 0; i < kw.len(); i++)
					seq.push_back({1'b0, kw[i]});
				case ($urandom_range(0, 3))
					0: seq.push_back({1'b0, rand_word_ch()});
					1: begin
						seq.push_back({1'b0, CH_HYPHEN});
						seq.push_back({1'b0, rand_word_ch()});
					end
					default: ;
				endcase
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 22) : $urandom_range(1, 10);
				seq.push_back({1'b0, rand_start_ch()});
				for (int i = 1; i < n; i++) begin
					if ($urandom_range(0, 7) == 0)
						repeat ($urandom_range(1, 3)) seq.push_back({1'b0, CH_HYPHEN});
					seq.push_back({1'b0, rand_word_ch()});
				end
			end
			// dangling hyphens are eaten but never committed
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) seq.push_back({1'b0, CH_HYPHEN});
			if ($urandom_range(0, 2) == 0) begin
				seq.push_back({1'b0, CH_LPAREN});
				repeat ($urandom_range(0, 6)) seq.push_back({1'b0, 8'($urandom_range(0, 255))});
				if ($urandom_range(0, 3) == 0)
					seq.push_back({1'b1, 8'($urandom_range(0, 255))});
				else
					seq.push_back({1'b0, CH_RPAREN});
			end
			case ($urandom_range(0, 4))
				0: seq.push_back({1'b1, 8'($urandom_range(0, 255))});
				1: seq.push_back({1'b0, rand_ws()});
				2: seq.push_back({1'b0, CH_LF});
				3: seq.push_back({1'b0, 8'($urandom_range(0, 255))});
				default: ;   // next start cuts this scan off
			endcase
		end
		for (int i = 0; i < seq.size(); i++)
			if (i == 0)
				add_item(1'b1, ac, at, seq[i][8], seq[i][7:0], hold);
			else
				add_item(1'b0, $urandom_range(0, 1), $urandom_range(0, 1), seq[i][8], seq[i][7:0]);
	endtask

	task automatic gen_noise();
		repeat ($urandom_range(1, 8))
			add_item($urandom_range(0, 5) == 0, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
	endtask

	// ---------------- sender ----------------

	char_xact_t drv_item;
	int         burst_left = 0;
	int         gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tuser  <= 4'h0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (chars_to_send.size() == 0 ||
				(chars_to_send[0].hold && (s_tvalid || scan_results_due.size() != 0))) begin
				// a held item goes only once the line is quiet and nothing is owed
				s_tvalid <= 1'b0;
			end else begin
				drv_item = chars_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= drv_item.ch;
				s_tuser  <= {drv_item.en, drv_item.at, drv_item.ac, drv_item.st};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// ---------------- receiver ----------------

	bit [15:0] stall_mask = 16'hFFFF;
	bit [7:0]  stall_phase = '0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 8'd1;
			if (stall_phase[5:0] == 6'd0) begin
				case ($urandom_range(0, 3))
					0: stall_mask <= 16'hFFFF;
					1: stall_mask <= 16'($urandom);
					2: stall_mask <= 16'($urandom) & 16'($urandom);
					default: stall_mask <= 16'($urandom) | 16'($urandom);
				endcase
			end
			m_tready <= stall_mask[stall_phase[3:0]];
		end
	end

	// ---------------- monitor and checker ----------------

	char_xact_t mon_item;
	res_t       mon_pred;
	res_t       mon_want;

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (s_tvalid && s_tready) begin
				chars_accepted++;
				mon_item.st = s_tuser[0];
				mon_item.ac = s_tuser[1];
				mon_item.at = s_tuser[2];
				mon_item.en = s_tuser[3];
				mon_item.ch = s_tdata;
				mon_item.hold = 1'b0;
				if (scan_step(mon_item, mon_pred))
					scan_results_due.push_back(mon_pred);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (scan_results_due.size() == 0) begin
					flag_mismatch("unexpected result", 0, {m_tuser, m_tdata});
				end else begin
					mon_want = scan_results_due.pop_front();
					if (m_tuser[2:0] !== mon_want.status)
						flag_mismatch("status", mon_want.status, m_tuser[2:0]);
					if (m_tuser[3] !== mon_want.token_kind)
						flag_mismatch("token_kind", mon_want.token_kind, m_tuser[3]);
					if (m_tdata[15:0] !== mon_want.skipped)
						flag_mismatch("skipped", mon_want.skipped, m_tdata[15:0]);
					if (m_tdata[31:16] !== mon_want.token_length)
						flag_mismatch("token_length", mon_want.token_length, m_tdata[31:16]);
					if (m_tdata[32] !== mon_want.overflow)
						flag_mismatch("overflow", mon_want.overflow, m_tdata[32]);
					if (m_tdata[39:33] !== 7'd0)
						flag_mismatch("pad bits", 0, m_tdata[39:33]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		int base;
		bit first_scan;

		// directed: idle character, no-token start, line ends, bad start
		add_item(1'b0, 1'b1, 1'b1, 1'b0, "a");
		add_item(1'b1, 1'b0, 1'b0, 1'b0, 8'hFF);
		add_item(1'b1, 1'b1, 1'b0, 1'b0, CH_LF);
		add_item(1'b1, 1'b0, 1'b1, 1'b0, CH_CR);
		add_item(1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
		add_item(1'b1, 1'b1, 1'b0, 1'b0, CH_DIG_9);
		// blanks then a reserved word
		add_item(1'b1, 1'b0, 1'b1, 1'b0, CH_TAB);
		add_char(CH_FF);
		add_char("n"); add_char("o"); add_char("t"); add_char("e");
		add_char(CH_SPACE);
		// trailing hyphen, then a paren list taken in
		add_item(1'b1, 1'b0, 1'b1, 1'b0, "a");
		add_char(CH_HYPHEN); add_char(CH_LPAREN); add_char(CH_RPAREN);
		// end of input inside the parens
		add_item(1'b1, 1'b0, 1'b1, 1'b0, "z");
		add_char(CH_LPAREN);
		add_eoi();
		// continuation word closed by end of input
		add_item(1'b1, 1'b1, 1'b0, 1'b0, "Q");
		add_char(CH_DIG_9);
		add_eoi();

		// random traffic: mostly well-formed scans, some raw noise
		base = chars_to_send.size();
		first_scan = 1'b1;
		while (chars_to_send.size() - base < RANDOM_ITEMS) begin
			if (!first_scan && $urandom_range(0, 7) == 0) begin
				gen_noise();
			end else begin
				gen_scan(first_scan || $urandom_range(0, 49) == 0);
				first_scan = 1'b0;
			end
		end
		total_chars = chars_to_send.size();

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (chars_accepted < total_chars)
			@(posedge clk);
		while (scan_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
